// File: design/ffc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ffc_pkg
// Shared types and constants for the fixed/double converter.
// ---------------------------------------------------------------------------
package ffc_pkg;

    localparam int DEFAULT_MAX_WORD_BITS = 32;
    localparam int WORD_W = 32;
    localparam int DBL_W  = 64;
    localparam int CFG_W  = 11;

    typedef enum logic [1:0] {
        CFG_WORD_BITS   = 2'd0,
        CFG_FRAC_BITS   = 2'd1,
        CFG_SIGNED_MODE = 2'd2
    } t_cfg_idx;

    localparam logic FUNC_FIX2DBL = 1'b0;
    localparam logic FUNC_DBL2FIX = 1'b1;

    // effective format, decoded from the configuration registers
    typedef struct packed {
        logic [5:0]         n;
        logic signed [11:0] f;
        logic               sgn;
        logic [WORD_W-1:0]  mask;
        logic [WORD_W-1:0]  max_w;
        logic [WORD_W-1:0]  min_w;
    } t_fmt;

endpackage
`default_nettype wire

// File: design/fixed_float_converter_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fixed_float_converter_unit
// Fixed-point word <-> binary64 converter, four-stage pipeline.
// ---------------------------------------------------------------------------
// Input channel: i_valid/o_ready carries one word (i_func, i_fixed_word,
// i_double_bits). i_func low converts the fixed word to a double, high
// converts the double to a fixed word; the unused result field reads 0.
// Output channel: o_valid/i_ready carries o_double_result/o_fixed_result.
// Format registers (word bits, fraction bits, signedness) are written on
// i_cfg_we with i_cfg_idx/i_cfg_data; write them only while the pipe is empty.
// The pipe is an input register plus three stages; one word enters every
// cycle while the output is not held. The pipe advances as one unit: when the
// output word is held by the receiver, every stage holds and o_ready drops, so
// nothing is lost. Bubbles inside the pipe are not squeezed out; they advance with it.
// Reset clears all valid bits and loads word bits 32, fraction 0, unsigned.
// ---------------------------------------------------------------------------
module fixed_float_converter_unit #(
    parameter int MAX_WORD_BITS = ffc_pkg::DEFAULT_MAX_WORD_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_func,
    input  wire logic [ffc_pkg::WORD_W-1:0]  i_fixed_word,
    input  wire logic [ffc_pkg::DBL_W-1:0]   i_double_bits,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [ffc_pkg::DBL_W-1:0]        o_double_result,
    output logic [ffc_pkg::WORD_W-1:0]       o_fixed_result,
    input  wire logic                        i_cfg_we,
    input  wire logic [1:0]                  i_cfg_idx,
    input  wire logic [ffc_pkg::CFG_W-1:0]   i_cfg_data
);
    logic        en;
    logic [3:0]  r_v;
    logic        r_func0;
    logic [31:0] r_fixed0;
    logic [63:0] r_dbl0;
    ffc_pkg::t_fmt fmt;

    assign en      = !r_v[3] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_func0  <= i_func;
            r_fixed0 <= i_fixed_word;
            r_dbl0   <= i_double_bits;
        end
    end

    ffc_cfg #(.MAX_WORD_BITS(MAX_WORD_BITS)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_fmt      (fmt)
    );

    ffc_f2d u_f2d (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_func   (r_func0),
        .i_word   (r_fixed0),
        .i_fmt    (fmt),
        .o_result (o_double_result)
    );

    ffc_d2f u_d2f (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_func   (r_func0),
        .i_dbl    (r_dbl0),
        .i_fmt    (fmt),
        .o_result (o_fixed_result)
    );
endmodule
`default_nettype wire

// File: design/ffc_cfg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ffc_cfg
// Configuration registers and registered decode of the effective format.
// ---------------------------------------------------------------------------
module ffc_cfg #(
    parameter int MAX_WORD_BITS = ffc_pkg::DEFAULT_MAX_WORD_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [1:0]               i_cfg_idx,
    input  wire logic [ffc_pkg::CFG_W-1:0] i_cfg_data,
    output ffc_pkg::t_fmt                 o_fmt
);
    localparam logic [5:0] MAX_N = 6'(MAX_WORD_BITS);

    logic [5:0]         r_word_bits;
    logic signed [10:0] r_frac_bits;
    logic               r_signed_mode;
    ffc_pkg::t_fmt      r_fmt;
    ffc_pkg::t_fmt      n_fmt;

    logic [5:0]         n_eff;
    logic signed [11:0] fx;
    logic signed [11:0] lo;
    logic signed [11:0] hi;
    logic [32:0]        mask33;
    logic [32:0]        sb33;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_bits   <= 6'd32;
            r_frac_bits   <= '0;
            r_signed_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (ffc_pkg::t_cfg_idx'(i_cfg_idx))
                ffc_pkg::CFG_WORD_BITS:   r_word_bits   <= i_cfg_data[5:0];
                ffc_pkg::CFG_FRAC_BITS:   r_frac_bits   <= $signed(i_cfg_data[10:0]);
                ffc_pkg::CFG_SIGNED_MODE: r_signed_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_word_bits == 6'd0) begin
            n_eff = 6'd1;
        end else if (r_word_bits > MAX_N) begin
            n_eff = MAX_N;
        end else begin
            n_eff = r_word_bits;
        end
        fx = {r_frac_bits[10], r_frac_bits};
        lo = $signed({6'b0, n_eff}) - 12'sd1024;
        hi = 12'sd1023 - $signed({6'b0, n_eff});
        mask33 = (33'd1 << n_eff) - 33'd1;
        sb33   = r_signed_mode ? (33'd1 << (n_eff - 6'd1)) : 33'd0;

        n_fmt.n     = n_eff;
        n_fmt.sgn   = r_signed_mode;
        if (fx < lo) begin
            n_fmt.f = lo;
        end else if (fx > hi) begin
            n_fmt.f = hi;
        end else begin
            n_fmt.f = fx;
        end
        n_fmt.mask  = mask33[31:0];
        n_fmt.max_w = mask33[31:0] ^ sb33[31:0];
        n_fmt.min_w = sb33[31:0];
    end

    always_ff @(posedge i_clk) begin
        r_fmt <= n_fmt;
    end

    assign o_fmt = r_fmt;
endmodule
`default_nettype wire

// File: design/ffc_f2d.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ffc_f2d
// Fixed to double: sign/magnitude, leading-zero count, normalize and pack.
// ---------------------------------------------------------------------------
module ffc_f2d (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic                       i_func,
    input  wire logic [ffc_pkg::WORD_W-1:0] i_word,
    input  ffc_pkg::t_fmt                   i_fmt,
    output logic [ffc_pkg::DBL_W-1:0]       o_result
);
    logic        r_sel1, r_neg1;
    logic [31:0] r_mag1;
    logic        r_sel2, r_neg2, r_zero2;
    logic [31:0] r_mag2;
    logic [4:0]  r_lz2;
    logic [63:0] r_res3;

    logic [31:0] w;
    logic        neg;
    logic [31:0] n_mag;
    logic [4:0]  n_lz;
    logic        found;
    logic [31:0] norm;
    logic signed [12:0] exp13;
    logic [63:0] n_res;

    always_comb begin
        w     = i_word & i_fmt.mask;
        neg   = i_fmt.sgn & w[i_fmt.n[4:0] - 5'd1];
        n_mag = neg ? ((~w + 32'd1) & i_fmt.mask) : w;
    end

    always_comb begin
        n_lz  = '0;
        found = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (!found && r_mag1[i]) begin
                n_lz  = 5'(31 - i);
                found = 1'b1;
            end
        end
    end

    always_comb begin
        norm  = r_mag2 << r_lz2;
        exp13 = 13'sd1054 - $signed({8'b0, r_lz2}) - $signed({i_fmt.f[11], i_fmt.f});
        if (!r_sel2 || r_zero2) begin
            n_res = '0;
        end else begin
            n_res = {r_neg2, exp13[10:0], norm[30:0], 21'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sel1  <= (i_func == ffc_pkg::FUNC_FIX2DBL);
            r_neg1  <= neg;
            r_mag1  <= n_mag;
            r_sel2  <= r_sel1;
            r_neg2  <= r_neg1;
            r_mag2  <= r_mag1;
            r_zero2 <= (r_mag1 == 32'd0);
            r_lz2   <= n_lz;
            r_res3  <= n_res;
        end
    end

    assign o_result = r_res3;
endmodule
`default_nettype wire

// File: design/ffc_d2f.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ffc_d2f
// Double to fixed: unpack and scale, align, then saturate/round/mask.
// ---------------------------------------------------------------------------
module ffc_d2f (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic                       i_func,
    input  wire logic [ffc_pkg::DBL_W-1:0]  i_dbl,
    input  ffc_pkg::t_fmt                   i_fmt,
    output logic [ffc_pkg::WORD_W-1:0]      o_result
);
    logic        r_sel1, r_neg1, r_nan1, r_big1;
    logic [52:0] r_m1;
    logic [5:0]  r_rsh1;
    logic        r_sel2, r_neg2, r_nan2, r_big2, r_half2, r_sticky2;
    logic [52:0] r_ip2;
    logic [31:0] r_res3;

    logic [10:0] expf;
    logic [51:0] man;
    logic        mnz;
    logic signed [12:0] e13;
    logic signed [12:0] k13;
    logic [12:0] negk;
    logic [5:0]  n_rsh;
    logic [52:0] n_m;

    logic [63:0] mext;
    logic [63:0] lowmask;
    logic [63:0] shr;

    logic [52:0] lim;
    logic        over;
    logic [31:0] t;
    logic [31:0] rr;
    logic [31:0] n_res;

    always_comb begin
        expf = i_dbl[62:52];
        man  = i_dbl[51:0];
        mnz  = (expf != 11'd0) || (man != 52'd0);
        n_m  = (expf == 11'd0) ? {1'b0, man} : {1'b1, man};
        e13  = (expf == 11'd0) ? -13'sd1074 : ($signed({2'b0, expf}) - 13'sd1075);
        k13  = e13 + $signed({i_fmt.f[11], i_fmt.f});
        negk = 13'(-k13);
        if (!k13[12]) begin
            n_rsh = '0;
        end else if (negk > 13'd63) begin
            n_rsh = 6'd63;
        end else begin
            n_rsh = negk[5:0];
        end
    end

    always_comb begin
        mext    = {11'b0, r_m1};
        lowmask = (64'd1 << r_rsh1) - 64'd1;
        shr     = mext >> r_rsh1;
    end

    always_comb begin
        lim  = r_neg2 ? {21'b0, i_fmt.min_w} : {21'b0, i_fmt.max_w};
        over = r_big2 || (r_ip2 > lim) || ((r_ip2 == lim) && r_sticky2);
        t    = r_ip2[31:0] + {31'b0, r_half2};
        rr   = (r_neg2 ? (32'd0 - t) : t) & i_fmt.mask;
        if (!r_sel2 || r_nan2) begin
            n_res = '0;
        end else if (over) begin
            n_res = r_neg2 ? i_fmt.min_w : i_fmt.max_w;
        end else begin
            n_res = rr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sel1    <= (i_func == ffc_pkg::FUNC_DBL2FIX);
            r_neg1    <= i_dbl[63];
            r_nan1    <= (expf == 11'h7FF) && (man != 52'd0);
            r_big1    <= !k13[12] && mnz;
            r_m1      <= n_m;
            r_rsh1    <= n_rsh;
            r_sel2    <= r_sel1;
            r_neg2    <= r_neg1;
            r_nan2    <= r_nan1;
            r_big2    <= r_big1;
            r_ip2     <= shr[52:0];
            r_half2   <= |(mext & (lowmask ^ (lowmask >> 1)));
            r_sticky2 <= |(mext & lowmask);
            r_res3    <= n_res;
        end
    end

    assign o_result = r_res3;
endmodule
`default_nettype wire

// File: design/ffc_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ffc_checker
// Port-level checks for the converter, bound to the top level.
// ---------------------------------------------------------------------------
module ffc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [63:0] o_double_result,
    input wire logic [31:0] o_fixed_result
);
    // a held output word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_double_result)
            && $stable(o_fixed_result))
        else $error("output word changed while stalled");

    // at most one result field carries a nonzero value
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_double_result == 64'd0) || (o_fixed_result == 32'd0))
        else $error("both result fields nonzero");

    // a stalled output blocks the input side
    a_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input accepted while output stalled");

    // reset empties the pipe
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
endmodule

bind fixed_float_converter_unit ffc_checker u_ffc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_double_result (o_double_result),
    .o_fixed_result  (o_fixed_result)
);
`default_nettype wire

// File: tb/fixed_float_converter_checker.sv
// ---------------------------------------------------------------------------
// fixed_float_converter_checker
// Watches the format writes and both word channels of the converter, predicts
// each result word from the accepted input word and the current format, and
// compares the results in order, field by field.
// ---------------------------------------------------------------------------
module fixed_float_converter_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic                        i_in_ready,
    input  wire logic                        i_func,
    input  wire logic [ffc_pkg::WORD_W-1:0]  i_fixed_word,
    input  wire logic [ffc_pkg::DBL_W-1:0]   i_double_bits,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_ready,
    input  wire logic [ffc_pkg::DBL_W-1:0]   i_double_result,
    input  wire logic [ffc_pkg::WORD_W-1:0]  i_fixed_result,
    input  wire logic                        i_cfg_we,
    input  wire logic [1:0]                  i_cfg_idx,
    input  wire logic [ffc_pkg::CFG_W-1:0]   i_cfg_data,
    output int                               o_errors,
    output int                               o_pending
);
    import ffc_pkg::*;

    typedef struct {
        logic [DBL_W-1:0]  dbl;
        logic [WORD_W-1:0] fix;
    } t_conv_result;

    t_conv_result      conv_queue[$];
    logic [5:0]        fmt_bits;
    logic signed [10:0] fmt_frac;
    logic              fmt_signed;
    int                step_errs;

    function automatic real exact_pow2(int e);
        if (e > 1023) e = 1023;
        if (e < -1074) e = -1074;
        if (e >= -1022) return $bitstoreal({1'b0, 11'(e + 1023), 52'b0});
        return $bitstoreal(64'd1 << (e + 1074));
    endfunction

    function automatic int eff_n();
        int n;
        n = fmt_bits;
        if (n < 1) n = 1;
        if (n > 32) n = 32;
        return n;
    endfunction

    function automatic int eff_f(int n);
        int f;
        f = fmt_frac;
        if (f < n - 1024) f = n - 1024;
        if (f > 1023 - n) f = 1023 - n;
        return f;
    endfunction

    function automatic real word_to_real(logic [63:0] w, int n, int f);
        logic [63:0] m;
        longint      v;
        m = w & ((64'd1 << n) - 1);
        v = longint'(m);
        if (fmt_signed && m[n-1]) v = v - (longint'(1) << n);
        return real'(v) * exact_pow2(-f);
    endfunction

    function automatic t_conv_result convert(logic func, logic [31:0] w, logic [63:0] d);
        t_conv_result res;
        int           n, f, sh;
        logic [63:0]  mask, sm, max_w, min_w, ab, mant, t2, t;
        real          x, s, a;
        logic         neg;
        n = eff_n();
        f = eff_f(n);
        mask = (64'd1 << n) - 1;
        sm = fmt_signed ? (64'd1 << (n - 1)) : 64'd0;
        max_w = mask ^ sm;
        min_w = sm;
        res.dbl = '0;
        res.fix = '0;
        if (func == FUNC_FIX2DBL) begin
            res.dbl = $realtobits(word_to_real({32'd0, w}, n, f));
            return res;
        end
        // NaN maps to zero
        if (d[62:52] == 11'h7FF && d[51:0] != 0) return res;
        x = $bitstoreal(d);
        if (x < word_to_real(min_w, n, f)) begin
            res.fix = min_w[31:0];
            return res;
        end
        if (x > word_to_real(max_w, n, f)) begin
            res.fix = max_w[31:0];
            return res;
        end
        s = x * exact_pow2(f);
        neg = s < 0.0;
        a = neg ? -s : s;
        if (a > 4294967296.0) a = 4294967296.0;
        // round half away from zero: keep one bit below the point, add one, drop it
        ab = $realtobits(a);
        if (ab[62:52] == 0) begin
            t = 0;
        end else begin
            mant = {11'd0, 1'b1, ab[51:0]};
            sh = int'(ab[62:52]) - 1023 - 52 + 1;
            if (sh >= 0) t2 = mant << sh;
            else if (-sh > 63) t2 = 0;
            else t2 = mant >> (-sh);
            t = (t2 + 1) >> 1;
        end
        if (neg) t = 64'd0 - t;
        res.fix = t[31:0] & mask[31:0];
        return res;
    endfunction

    assign o_pending = conv_queue.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fmt_bits <= 6'd32;
            fmt_frac <= '0;
            fmt_signed <= 1'b0;
            conv_queue.delete();
            o_errors <= 0;
        end else begin
            step_errs = 0;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_WORD_BITS: fmt_bits <= i_cfg_data[5:0];
                    CFG_FRAC_BITS: fmt_frac <= i_cfg_data;
                    CFG_SIGNED_MODE: fmt_signed <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_ready) begin
                if (conv_queue.size() == 0) begin
                    $error("result word with nothing expected: dbl=%h fix=%h",
                           i_double_result, i_fixed_result);
                    step_errs = step_errs + 1;
                end else begin
                    t_conv_result exp_res;
                    exp_res = conv_queue.pop_front();
                    if (exp_res.dbl !== i_double_result) begin
                        $error("double_result: expected %h, got %h",
                               exp_res.dbl, i_double_result);
                        step_errs = step_errs + 1;
                    end
                    if (exp_res.fix !== i_fixed_result) begin
                        $error("fixed_result: expected %h, got %h",
                               exp_res.fix, i_fixed_result);
                        step_errs = step_errs + 1;
                    end
                end
            end
            if (step_errs != 0)
                o_errors <= o_errors + step_errs;
            if (i_valid && i_in_ready)
                conv_queue.push_back(convert(i_func, i_fixed_word, i_double_bits));
        end
    end

endmodule

// File: tb/fixed_float_converter_unit_tb.sv
// ---------------------------------------------------------------------------
// fixed_float_converter_unit_tb
// Drives directed and random conversion words through the converter under a
// series of formats (extremes included), with random gaps on the sender and
// random stalls on the receiver; a checker module predicts and compares.
// ---------------------------------------------------------------------------
module fixed_float_converter_unit_tb;
    import ffc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PIPE_LATENCY = 4;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_func = FUNC_FIX2DBL;
    logic [WORD_W-1:0]  i_fixed_word = '0;
    logic [DBL_W-1:0]   i_double_bits = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [DBL_W-1:0]   o_double_result;
    logic [WORD_W-1:0]  o_fixed_result;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [CFG_W-1:0]   i_cfg_data = '0;

    int errors, pending;
    int stall_left = 0;
    bit no_idle = 0;
    int idle_cycles = 0;
    int words_sent = 0, formats_used = 0;
    int cur_n = 32, cur_f = 0;
    bit cur_sgn = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    fixed_float_converter_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_func(i_func), .i_fixed_word(i_fixed_word), .i_double_bits(i_double_bits),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_double_result(o_double_result), .o_fixed_result(o_fixed_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    fixed_float_converter_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_in_ready(o_ready),
        .i_func(i_func), .i_fixed_word(i_fixed_word), .i_double_bits(i_double_bits),
        .i_out_valid(o_valid), .i_ready(i_ready),
        .i_double_result(o_double_result), .i_fixed_result(o_fixed_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver: stall at random before taking each word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                int k;
                k = no_idle ? 0 : $urandom_range(0, 8);
                stall_left <= k;
                i_ready <= (k == 0);
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_ready <= (stall_left == 1);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic real pow2_stim(int e);
        if (e > 1023) e = 1023;
        if (e < -1074) e = -1074;
        if (e >= -1022) return $bitstoreal({1'b0, 11'(e + 1023), 52'b0});
        return $bitstoreal(64'd1 << (e + 1074));
    endfunction

    // doubles on, between and just past the format grid; random; special values
    function automatic logic [63:0] pick_double();
        int   n, f, kind;
        longint v;
        logic [63:0] m, r;
        real  off;
        n = cur_n < 1 ? 1 : (cur_n > 32 ? 32 : cur_n);
        f = cur_f;
        if (f < n - 1024) f = n - 1024;
        if (f > 1023 - n) f = 1023 - n;
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            m = {32'd0, $urandom()} & ((64'd1 << n) - 1);
            if ($urandom_range(0, 3) == 0) m = $urandom_range(0, 1) ? 64'd0 : ((64'd1 << n) - 1);
            v = longint'(m);
            if (cur_sgn && m[n-1]) v = v - (longint'(1) << n);
            case ($urandom_range(0, 5))
                0: off = 0.0;
                1: off = 0.5;
                2: off = -0.5;
                3: off = 0.25;
                4: off = 0.75;
                default: off = 1.5;
            endcase
            return $realtobits((real'(v) + off) * pow2_stim(-f));
        end else if (kind == 6) begin
            return {$urandom(), $urandom()};
        end else if (kind == 7) begin
            r = {$urandom(), $urandom()};
            r[62:52] = 11'(1023 - f + $urandom_range(0, 70) - 40);
            return r;
        end
        case ($urandom_range(0, 6))
            0: return 64'h7FF0_0000_0000_0000;
            1: return 64'hFFF0_0000_0000_0000;
            2: return {1'b0, 11'h7FF, 20'd0, $urandom()} | 64'd1;
            3: return 64'h8000_0000_0000_0000;
            4: return 64'h0000_0000_0000_0001;
            5: return 64'h800F_FFFF_FFFF_FFFF;
            default: return 64'h0;
        endcase
    endfunction

    task automatic send_word(logic func, logic [31:0] w, logic [63:0] d);
        int  gap;
        bit  taken;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= func;
        i_fixed_word <= w;
        i_double_bits <= d;
        do begin
            @(negedge i_clk);
            taken = o_ready;
            @(posedge i_clk);
        end while (!taken);
        words_sent++;
    endtask

    task automatic set_format(int n, int f, bit sgn);
        // drain the pipe before touching the format
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_WORD_BITS;
        i_cfg_data <= CFG_W'(n);
        @(posedge i_clk);
        i_cfg_idx <= CFG_FRAC_BITS;
        i_cfg_data <= CFG_W'(f);
        @(posedge i_clk);
        i_cfg_idx <= CFG_SIGNED_MODE;
        i_cfg_data <= CFG_W'(sgn);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_n = n;
        cur_f = f;
        cur_sgn = sgn;
        formats_used++;
    endtask

    task automatic random_words(int count);
        repeat (count) begin
            if ($urandom_range(0, 1))
                send_word(FUNC_DBL2FIX, $urandom(), pick_double());
            else
                send_word(FUNC_FIX2DBL, $urandom_range(0, 3) == 0 ?
                          (32'd1 << $urandom_range(0, 31)) ^ {32{$urandom_range(0, 1) == 1}} :
                          $urandom(), {$urandom(), $urandom()});
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset format: 32 bits, unsigned, integer
        send_word(FUNC_FIX2DBL, 32'h0000_0000, '0);
        send_word(FUNC_FIX2DBL, 32'hFFFF_FFFF, '1);
        send_word(FUNC_FIX2DBL, 32'h0000_0001, '0);
        send_word(FUNC_DBL2FIX, '1, $realtobits(2.5));
        send_word(FUNC_DBL2FIX, '0, $realtobits(1.5));
        send_word(FUNC_DBL2FIX, '0, $realtobits(0.49));
        send_word(FUNC_DBL2FIX, '0, $realtobits(4294967295.4));
        send_word(FUNC_DBL2FIX, '0, $realtobits(4294967295.6));
        send_word(FUNC_DBL2FIX, '0, $realtobits(-1.0));
        send_word(FUNC_DBL2FIX, '0, 64'h7FF0_0000_0000_0000);
        send_word(FUNC_DBL2FIX, '0, 64'hFFF0_0000_0000_0000);
        send_word(FUNC_DBL2FIX, '0, 64'h7FF8_0000_0000_0001);
        send_word(FUNC_DBL2FIX, '0, 64'h8000_0000_0000_0000);
        send_word(FUNC_DBL2FIX, '0, 64'h0000_0000_0000_0001);

        set_format(8, 4, 1);
        send_word(FUNC_FIX2DBL, 32'h0000_0080, '0);
        send_word(FUNC_FIX2DBL, 32'hFFFF_FF7F, '0);
        send_word(FUNC_DBL2FIX, '0, $realtobits(-8.0));
        send_word(FUNC_DBL2FIX, '0, $realtobits(-8.03125));
        send_word(FUNC_DBL2FIX, '0, $realtobits(7.9375));
        send_word(FUNC_DBL2FIX, '0, $realtobits(-0.03125));
        send_word(FUNC_DBL2FIX, '0, $realtobits(1.0e300));

        // extremes: word size below and above range, fraction clamped both ways
        set_format(0, -1024, 0);
        random_words(40);
        set_format(63, 1023, 1);
        random_words(40);
        set_format(1, 1023, 1);
        random_words(40);
        set_format(32, -1024, 1);
        random_words(40);
        set_format(32, 1023, 0);
        random_words(40);

        repeat (14) begin
            int n, f;
            n = $urandom_range(0, 7) == 0 ? $urandom_range(0, 63) : $urandom_range(1, 32);
            f = $urandom_range(0, 4) == 0 ? int'($urandom_range(0, 2047)) - 1024
                                          : int'($urandom_range(0, 80)) - 40;
            set_format(n, f, $urandom_range(0, 1));
            no_idle = ($urandom_range(0, 3) == 0);
            random_words(90);
        end
        no_idle = 0;

        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);

        $display("Converted %0d words across %0d format settings, both directions.",
                 words_sent, formats_used);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
design/ffc_pkg.sv
design/ffc_cfg.sv
design/ffc_f2d.sv
design/ffc_d2f.sv
design/fixed_float_converter_unit.sv
design/ffc_checker.sv
tb/fixed_float_converter_checker.sv
tb/fixed_float_converter_unit_tb.sv
